@@ rtl/trajectory_costmap_critic_unit_macros.svh @@
// ============================================================================
// Trajectory costmap critic assertion macros
// Shared concurrent assertion forms for the critic RTL.
// ============================================================================
`ifndef TRAJECTORY_COSTMAP_CRITIC_UNIT_MACROS_SVH
`define TRAJECTORY_COSTMAP_CRITIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tccc_pkg.sv @@
// ============================================================================
// Trajectory costmap critic package
// Types and constants shared by the critic modules.
// ============================================================================
`default_nettype none

package tccc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COST_W      = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRIT_PENALTY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLL_PENALTY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TRACK_UNKNOWN = 3'd5;

    localparam logic [7:0] CELL_UNKNOWN   = 8'd255;
    localparam logic [7:0] CELL_LETHAL    = 8'd254;
    localparam logic [7:0] CELL_INSCRIBED = 8'd253;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic        start;
        logic [31:0] run;
        logic [31:0] scale;
        logic [2:0]  exponent;
    } eng_req_t;

    typedef struct packed {
        logic              done;
        logic [COST_W-1:0] cost;
    } eng_rsp_t;

endpackage

`default_nettype wire

@@ rtl/tccc_ifs.sv @@
// ============================================================================
// Trajectory costmap critic channels
// Valid/ready channels for trajectory points and trajectory results.
// ============================================================================
`default_nettype none

interface tccc_point_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_cost;
    logic       outside_map;
    logic       near_goal;
    logic       last_point;
    logic       last_trajectory;

    modport source (output valid, cell_cost, outside_map, near_goal, last_point,
                    last_trajectory, input ready);
    modport sink (input valid, cell_cost, outside_map, near_goal, last_point,
                  last_trajectory, output ready);
endinterface

interface tccc_result_if;
    logic        valid;
    logic        ready;
    logic [47:0] trajectory_cost;
    logic        collided;
    logic        all_collided;
    logic        batch_done;

    modport source (output valid, trajectory_cost, collided, all_collided, batch_done,
                    input ready);
    modport sink (input valid, trajectory_cost, collided, all_collided, batch_done,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/tccc_cost_engine.sv @@
// ============================================================================
// Trajectory costmap critic cost engine
// Scales the accumulated cost and raises it to the configured power with one
// shared 32 by 32 multiplier under a small sequencer.
// ============================================================================
`default_nettype none

module tccc_cost_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tccc_pkg::eng_req_t req,
    input  wire logic               ack,
    output tccc_pkg::eng_rsp_t      rsp
);

    typedef enum logic [4:0] {
        E_IDLE = 5'b00001,
        E_BASE = 5'b00010,
        E_PMUL = 5'b00100,
        E_PACC = 5'b01000,
        E_DONE = 5'b10000
    } eng_state_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_24 = 2'd1,
        SH_48 = 2'd2
    } shift_t;

    eng_state_t  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  step_reg, step_next;
    shift_t      sh_reg, sh_next;
    logic [31:0] run_reg, run_next;
    logic [31:0] scale_reg, scale_next;
    logic [47:0] base_reg, base_next;
    logic [47:0] acc_reg, acc_next;
    logic [47:0] pp_reg, pp_next;
    logic [95:0] sum_reg, sum_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [95:0] pp_shifted;
    logic [95:0] sum_add;
    shift_t      step_sh;

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        if (state_reg == E_BASE)
        begin
            mul_a = run_reg;
            mul_b = scale_reg;
        end
        else
        begin
            case (step_reg)
                2'd0:
                begin
                    mul_a = {8'd0, acc_reg[23:0]};
                    mul_b = {8'd0, base_reg[23:0]};
                end
                2'd1:
                begin
                    mul_a = {8'd0, acc_reg[23:0]};
                    mul_b = {8'd0, base_reg[47:24]};
                end
                2'd2:
                begin
                    mul_a = {8'd0, acc_reg[47:24]};
                    mul_b = {8'd0, base_reg[23:0]};
                end
                default:
                begin
                    mul_a = {8'd0, acc_reg[47:24]};
                    mul_b = {8'd0, base_reg[47:24]};
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (step_reg)
            2'd0:    step_sh = SH_0;
            2'd3:    step_sh = SH_48;
            default: step_sh = SH_24;
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            SH_0:    pp_shifted = {48'd0, pp_reg};
            SH_24:   pp_shifted = {24'd0, pp_reg, 24'd0};
            SH_48:   pp_shifted = {pp_reg, 48'd0};
            default: pp_shifted = 96'd0;
        endcase
    end

    assign sum_add = sum_reg + pp_shifted;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        sh_next    = sh_reg;
        run_next   = run_reg;
        scale_next = scale_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        sum_next   = sum_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    run_next   = req.run;
                    scale_next = req.scale;
                    cnt_next   = (req.exponent == 3'd0) ? 3'd0 : req.exponent - 3'd1;
                    state_next = E_BASE;
                end
            end
            E_BASE:
            begin
                base_next = mul_p[63:16];
                acc_next  = mul_p[63:16];
                step_next = 2'd0;
                state_next = (cnt_reg == 3'd0) ? E_DONE : E_PMUL;
            end
            E_PMUL:
            begin
                pp_next   = mul_p[47:0];
                sh_next   = step_sh;
                sum_next  = (step_reg == 2'd0) ? 96'd0 : sum_add;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = E_PACC;
                end
            end
            E_PACC:
            begin
                acc_next   = (|sum_add[95:56]) ? tccc_pkg::COST_MAX : sum_add[55:8];
                cnt_next   = cnt_reg - 3'd1;
                step_next  = 2'd0;
                state_next = (cnt_reg == 3'd1) ? E_DONE : E_PMUL;
            end
            E_DONE:
            begin
                if (ack)
                begin
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= 3'd0;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        run_reg   <= run_next;
        scale_reg <= scale_next;
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        pp_reg    <= pp_next;
        sum_reg   <= sum_next;
    end

    assign rsp.done = (state_reg == E_DONE);
    assign rsp.cost = acc_reg;

endmodule

`default_nettype wire

@@ rtl/trajectory_costmap_critic_unit.sv @@
// ============================================================================
// Trajectory costmap critic
// Scores sampled trajectories point by point against costmap cell costs.
// ============================================================================
// Points arrive on the point channel and results leave on the result channel,
// both valid/ready; an item moves at a clock edge with valid and ready high.
// A point that does not close a trajectory is folded into the running cost in
// the cycle it is accepted, so such points stream at one item per cycle while
// not busy. A point with last_point set starts the cost engine, and the point
// channel is not ready until the result is loaded into the output register.
// The engine scales once, then runs a multiply-accumulate pass per power step
// on its shared multiplier (exponent zero counts as one). The result register
// frees the input side as soon as it is loaded, so a stalled receiver only
// holds the block once a second result is ready. Registers are written on the
// plain write port while the block is idle; the user ensures this, not the
// block. Reset restores the register defaults, clears the running cost and
// collision flag, and sets the batch collision flag.
// ============================================================================
`default_nettype none

`include "trajectory_costmap_critic_unit_macros.svh"

module trajectory_costmap_critic_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    tccc_point_if.sink                              point,
    tccc_result_if.source                           result,
    input  wire logic                               cfg_write,
    input  wire logic [tccc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tccc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [7:0]  near_level_reg;
    logic [15:0] crit_penalty_reg;
    logic [23:0] coll_penalty_reg;
    logic [2:0]  exponent_reg;
    logic [31:0] scale_reg;
    logic        track_unknown_reg;

    logic [31:0] run_reg, run_next;
    logic        hit_reg, hit_next;
    logic        all_hit_reg, all_hit_next;
    logic        busy_reg, busy_next;
    logic        last_traj_reg;
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_cost_reg;
    logic        out_coll_reg;
    logic        out_all_reg;
    logic        out_done_reg;

    logic        pt_accept;
    logic [7:0]  eff_cost;
    logic        collide;
    logic [32:0] add_sum;
    logic [31:0] add_val;
    logic [31:0] run_upd;
    logic        hit_upd;
    logic        out_free;
    logic        eng_ack;

    tccc_pkg::eng_req_t eng_req;
    tccc_pkg::eng_rsp_t eng_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_level_reg    <= 8'd253;
            crit_penalty_reg  <= 16'd300;
            coll_penalty_reg  <= 24'd1000000;
            exponent_reg      <= 3'd1;
            scale_reg         <= 32'd660520;
            track_unknown_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tccc_pkg::REG_NEAR_LEVEL:    near_level_reg    <= cfg_data[7:0];
                tccc_pkg::REG_CRIT_PENALTY:  crit_penalty_reg  <= cfg_data[15:0];
                tccc_pkg::REG_COLL_PENALTY:  coll_penalty_reg  <= cfg_data[23:0];
                tccc_pkg::REG_EXPONENT:      exponent_reg      <= cfg_data[2:0];
                tccc_pkg::REG_SCALE:         scale_reg         <= cfg_data[31:0];
                tccc_pkg::REG_TRACK_UNKNOWN: track_unknown_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign point.ready = !busy_reg;
    assign pt_accept   = point.valid && point.ready;

    assign eff_cost = point.outside_map ? tccc_pkg::CELL_UNKNOWN : point.cell_cost;
    assign collide  = (eff_cost == tccc_pkg::CELL_LETHAL) ||
                      (eff_cost == tccc_pkg::CELL_INSCRIBED) ||
                      ((eff_cost == tccc_pkg::CELL_UNKNOWN) && !track_unknown_reg);
    assign add_val  = (eff_cost >= near_level_reg) ? {16'd0, crit_penalty_reg}
                                                   : {24'd0, eff_cost};
    assign add_sum  = {1'b0, run_reg} + {1'b0, add_val};

    always_comb
    begin
        run_upd = run_reg;
        hit_upd = hit_reg;
        if (!hit_reg && (eff_cost != 8'd0))
        begin
            if (collide)
            begin
                run_upd = {8'd0, coll_penalty_reg};
                hit_upd = 1'b1;
            end
            else if ((eff_cost >= near_level_reg) || !point.near_goal)
            begin
                run_upd = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
            end
        end
    end

    assign out_free = !out_valid_reg || result.ready;
    assign eng_ack  = eng_rsp.done && out_free;

    assign eng_req.start    = pt_accept && point.last_point;
    assign eng_req.run      = run_upd;
    assign eng_req.scale    = scale_reg;
    assign eng_req.exponent = exponent_reg;

    tccc_cost_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .ack   (eng_ack),
        .rsp   (eng_rsp)
    );

    always_comb
    begin
        run_next       = run_reg;
        hit_next       = hit_reg;
        all_hit_next   = all_hit_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pt_accept)
        begin
            run_next = run_upd;
            hit_next = hit_upd;
            if (point.last_point)
            begin
                busy_next = 1'b1;
            end
        end
        if (eng_ack)
        begin
            run_next       = 32'd0;
            hit_next       = 1'b0;
            all_hit_next   = last_traj_reg ? 1'b1 : (all_hit_reg && hit_reg);
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 32'd0;
            hit_reg       <= 1'b0;
            all_hit_reg   <= 1'b1;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            hit_reg       <= hit_next;
            all_hit_reg   <= all_hit_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_accept && point.last_point)
        begin
            last_traj_reg <= point.last_trajectory;
        end
        if (eng_ack)
        begin
            out_cost_reg <= eng_rsp.cost;
            out_coll_reg <= hit_reg;
            out_all_reg  <= last_traj_reg && all_hit_reg && hit_reg;
            out_done_reg <= last_traj_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.trajectory_cost = out_cost_reg;
    assign result.collided        = out_coll_reg;
    assign result.all_collided    = out_all_reg;
    assign result.batch_done      = out_done_reg;

    `TCCC_ASSERT_NEXT(a_close_sets_busy, clk, rst_n, pt_accept && point.last_point, busy_reg, "closing point did not hold off the point channel")
    `TCCC_ASSERT_NEXT(a_engine_holds, clk, rst_n, eng_rsp.done && !out_free, eng_rsp.done && $stable(eng_rsp.cost), "engine dropped a result that was not taken")
    `TCCC_ASSERT_SAME(a_all_implies_hit, clk, rst_n, result.valid && result.all_collided, result.collided, "all_collided without collided")
    `TCCC_ASSERT_SAME(a_all_only_at_end, clk, rst_n, result.valid && !result.batch_done, !result.all_collided, "all_collided outside the closing result")
    `TCCC_ASSERT_SAME(a_engine_busy, clk, rst_n, eng_rsp.done, busy_reg, "engine finished while the block was idle")

endmodule

`default_nettype wire
